>>> rtl/rlbm_pkg.sv
// Shared constants, types and luma tables for the RGB layer blend mixer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rlbm_pkg;

  localparam int NumStages = 10;
  localparam int DivSteps  = 8;
  localparam int NumLanes  = 3;

  typedef enum logic [2:0] {
    MODE_MUL     = 3'd0,
    MODE_SCREEN  = 3'd1,
    MODE_DARKEN  = 3'd2,
    MODE_LIGHTEN = 3'd3,
    MODE_OVERLAY = 3'd4,
    MODE_DODGE   = 3'd5,
    MODE_BURN    = 3'd6
  } mode_e;

  localparam logic CFG_IDX_MODE   = 1'b0;
  localparam logic CFG_IDX_AMOUNT = 1'b1;

  localparam logic [2:0] ModeReset   = 3'd0;
  localparam logic [7:0] AmountReset = 8'd128;

  typedef struct packed {
    logic pick_a;
    logic ovl_mul;
  } pick_t;

  typedef logic [23:0] luma_tab_t [256];

  localparam longint unsigned LumaDen = 64'd255000;
  localparam longint unsigned LumaOff = (64'd16 << 16) + 64'd32768;

  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic luma_tab_t build_luma(input longint unsigned w,
                                           input longint unsigned off);
    luma_tab_t t;
    longint unsigned num;
    for (int v = 0; v < 256; v++) begin
      num  = w * longint'(v) * 64'd219 * 64'd65536;
      t[v] = 24'(udiv64(2 * num + LumaDen, 2 * LumaDen) + off);
    end
    return t;
  endfunction

  localparam luma_tab_t LumaTab0 = build_luma(64'd114, LumaOff);
  localparam luma_tab_t LumaTab1 = build_luma(64'd587, 64'd0);
  localparam luma_tab_t LumaTab2 = build_luma(64'd299, 64'd0);

endpackage

`default_nettype wire

>>> rtl/rlbm_luma.sv
// Luma of both pixels, compare, and delay of the selection flags.
// Depends on rlbm_pkg.
`default_nettype none

module rlbm_luma import rlbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [NumStages-1:0] en_i,
  input  wire logic [2:0]           mode_i,
  input  wire logic [7:0]           a_chan0_i,
  input  wire logic [7:0]           a_chan1_i,
  input  wire logic [7:0]           a_chan2_i,
  input  wire logic [7:0]           b_chan0_i,
  input  wire logic [7:0]           b_chan1_i,
  input  wire logic [7:0]           b_chan2_i,
  output pick_t                     pick_o
);

  logic [23:0] sum_a, sum_b;
  logic [7:0]  la_q, lb_q;
  pick_t       pick_d;
  pick_t       pick_q [NumStages-1];

  assign sum_a = LumaTab0[a_chan0_i] + LumaTab1[a_chan1_i] + LumaTab2[a_chan2_i];
  assign sum_b = LumaTab0[b_chan0_i] + LumaTab1[b_chan1_i] + LumaTab2[b_chan2_i];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      la_q <= sum_a[23:16];
      lb_q <= sum_b[23:16];
    end
  end

  always_comb begin
    pick_d.pick_a  = (mode_i == MODE_DARKEN) ? (la_q <= lb_q) : (la_q >= lb_q);
    pick_d.ovl_mul = la_q < 8'd128;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pick_q[1] <= pick_d;
    end
  end

  for (genvar s = 2; s < NumStages - 1; s++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        pick_q[s] <= pick_q[s-1];
      end
    end
  end

  assign pick_o = pick_q[NumStages-2];

endmodule

`default_nettype wire

>>> rtl/rlbm_lane.sv
// One color channel: multiply, screen, pipelined divide, mode select, crossfade.
// Depends on rlbm_pkg.
`default_nettype none

module rlbm_lane import rlbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [NumStages-1:0] en_i,
  input  wire logic [2:0]           mode_i,
  input  wire logic [7:0]           amount_i,
  input  wire logic [7:0]           a_i,
  input  wire logic [7:0]           b_i,
  input  wire pick_t                pick_i,
  output logic [7:0]                res_o
);

  localparam int LastDiv = DivSteps;

  logic [7:0] a_q   [LastDiv+1];
  logic [7:0] b_q   [LastDiv+1];
  logic [7:0] mul_q [LastDiv+1];
  logic [7:0] scr_q [LastDiv+1];
  logic [7:0] d_q   [LastDiv+1];
  logic [7:0] r_q   [LastDiv+1];
  logic [7:0] quo_q [LastDiv+1];
  logic       sat_q [LastDiv+1];
  logic       spc_q [LastDiv+1];

  logic [15:0] prod_ab, prod_nn;
  logic [7:0]  na, nb, x0, d0;
  logic [7:0]  res_q;

  assign na      = 8'd255 - a_i;
  assign nb      = 8'd255 - b_i;
  assign prod_ab = a_i * b_i;
  assign prod_nn = na * nb;
  assign x0      = (mode_i == MODE_DODGE) ? a_i : na;
  assign d0      = (mode_i == MODE_DODGE) ? nb : b_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q[0]   <= a_i;
      b_q[0]   <= b_i;
      mul_q[0] <= prod_ab[15:8];
      scr_q[0] <= 8'd255 - prod_nn[15:8];
      d_q[0]   <= d0;
      r_q[0]   <= x0;
      quo_q[0] <= '0;
      sat_q[0] <= x0 >= d0;
      spc_q[0] <= (mode_i == MODE_DODGE) ? (b_i == 8'd255) : (b_i == 8'd0);
    end
  end

  for (genvar s = 1; s <= LastDiv; s++) begin : g_div
    logic [8:0] t;
    logic [8:0] diff;
    logic       ge;
    assign t    = {r_q[s-1], 1'b0};
    assign diff = t - {1'b0, d_q[s-1]};
    assign ge   = t >= {1'b0, d_q[s-1]};
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        a_q[s]   <= a_q[s-1];
        b_q[s]   <= b_q[s-1];
        mul_q[s] <= mul_q[s-1];
        scr_q[s] <= scr_q[s-1];
        d_q[s]   <= d_q[s-1];
        r_q[s]   <= ge ? diff[7:0] : t[7:0];
        quo_q[s] <= {quo_q[s-1][6:0], ge};
        sat_q[s] <= sat_q[s-1];
        spc_q[s] <= spc_q[s-1];
      end
    end
  end

  logic [7:0]  pa, pb, p;
  logic [7:0]  dodge_v, burn_v;
  logic [7:0]  twice, f, nf, g, h, wp, wo, other;
  logic [16:0] mix;

  assign pa = a_q[LastDiv];
  assign pb = b_q[LastDiv];

  always_comb begin
    dodge_v = (spc_q[LastDiv] || sat_q[LastDiv]) ? 8'd255 : quo_q[LastDiv];
    burn_v  = spc_q[LastDiv] ? 8'd0 :
              (sat_q[LastDiv] ? 8'd0 : 8'd255 - quo_q[LastDiv]);
    case (mode_i)
      MODE_MUL:     p = mul_q[LastDiv];
      MODE_SCREEN:  p = scr_q[LastDiv];
      MODE_DARKEN:  p = pick_i.pick_a ? pa : pb;
      MODE_LIGHTEN: p = pick_i.pick_a ? pa : pb;
      MODE_OVERLAY: p = pick_i.ovl_mul ? mul_q[LastDiv] : scr_q[LastDiv];
      MODE_DODGE:   p = dodge_v;
      MODE_BURN:    p = burn_v;
      default:      p = pa;
    endcase
  end

  always_comb begin
    twice = {amount_i[6:0], 1'b0};
    f     = twice;
    nf    = 8'd255 - twice;
    g     = 8'd254 - twice;
    h     = twice;
    if (amount_i[7]) begin
      wp    = g;
      wo    = h;
      other = pb;
    end else begin
      wp    = f;
      wo    = nf;
      other = pa;
    end
    mix = 17'(wp * p) + 17'(wo * other);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NumStages-1]) begin
      res_q <= mix[15:8];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/rgb_layer_blend_mixer.sv
// Top level of the RGB layer blend mixer: config registers, stage valids,
// three channel lanes and the shared luma unit. Depends on rlbm_pkg, rlbm_luma, rlbm_lane.
//
// One pixel pair enters per clock when the output does not stall. Each pair passes an input
// register, then the eight-stage restoring divider that each channel lane
// runs for dodge and burn. Stages advance independently, so bubbles close up and
// new items are accepted while a finished result waits. Write configuration only
// while the pipeline is empty.
`default_nettype none

module rgb_layer_blend_mixer import rlbm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] a_chan0_i,
  input  wire logic [7:0] a_chan1_i,
  input  wire logic [7:0] a_chan2_i,
  input  wire logic [7:0] b_chan0_i,
  input  wire logic [7:0] b_chan1_i,
  input  wire logic [7:0] b_chan2_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] out_chan0_o,
  output      logic [7:0] out_chan1_o,
  output      logic [7:0] out_chan2_o
);

  logic [2:0]           mode_q;
  logic [7:0]           amount_q;
  logic [NumStages-1:0] v_q, v_d, en;
  pick_t                pick;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeReset;
      amount_q <= AmountReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_MODE) begin
        mode_q <= cfg_data_i[2:0];
      end else begin
        amount_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
    for (int s = 0; s < NumStages; s++) begin
      if (s == 0) v_d[s] = en[s] ? in_valid_i : v_q[s];
      else        v_d[s] = en[s] ? v_q[s-1]   : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  rlbm_luma u_luma (
    .clk_i     (clk_i),
    .en_i      (en),
    .mode_i    (mode_q),
    .a_chan0_i (a_chan0_i),
    .a_chan1_i (a_chan1_i),
    .a_chan2_i (a_chan2_i),
    .b_chan0_i (b_chan0_i),
    .b_chan1_i (b_chan1_i),
    .b_chan2_i (b_chan2_i),
    .pick_o    (pick)
  );

  rlbm_lane u_lane0 (
    .clk_i(clk_i), .en_i(en), .mode_i(mode_q), .amount_i(amount_q),
    .a_i(a_chan0_i), .b_i(b_chan0_i), .pick_i(pick), .res_o(out_chan0_o)
  );

  rlbm_lane u_lane1 (
    .clk_i(clk_i), .en_i(en), .mode_i(mode_q), .amount_i(amount_q),
    .a_i(a_chan1_i), .b_i(b_chan1_i), .pick_i(pick), .res_o(out_chan1_o)
  );

  rlbm_lane u_lane2 (
    .clk_i(clk_i), .en_i(en), .mode_i(mode_q), .amount_i(amount_q),
    .a_i(a_chan2_i), .b_i(b_chan2_i), .pick_i(pick), .res_o(out_chan2_o)
  );

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_ready_i |-> !in_ready_o)
    else $error("accepted an item into a full stalled pipeline");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted item lost at first stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NumStages-2] && en[NumStages-1] |=> out_valid_o)
    else $error("item lost entering output stage");

endmodule

`default_nettype wire

>>> tb/sv/tb_rgb_layer_blend_mixer.sv
// Testbench for rgb_layer_blend_mixer: random and directed pixel pairs over all modes
// and varied amounts, checked against an in-bench blend predictor. Depends on rlbm_pkg.
`default_nettype none

module tb_rgb_layer_blend_mixer;
  import rlbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] a [3];
    logic [7:0] b [3];
  } pair_t;

  typedef struct {
    logic [7:0] c [3];
  } pix_t;

  class blend_board;
    logic [2:0] mode;
    logic [7:0] amt;
    pix_t       pending [$];
    int         errors;

    function new();
      mode   = ModeReset;
      amt    = AmountReset;
      errors = 0;
    endfunction

    function automatic int unsigned luma(logic [7:0] p [3]);
      longint unsigned t0, t1, t2, n;
      n  = 64'd114 * p[0] * 219 * 65536;
      t0 = (2 * n + 255000) / 510000 + (64'd16 << 16) + 32768;
      n  = 64'd587 * p[1] * 219 * 65536;
      t1 = (2 * n + 255000) / 510000;
      n  = 64'd299 * p[2] * 219 * 65536;
      t2 = (2 * n + 255000) / 510000;
      return ((t0 + t1 + t2) >> 16) & 8'hff;
    endfunction

    function automatic int unsigned mul8(int unsigned x, int unsigned y);
      return (x * y) >> 8;
    endfunction

    function automatic int unsigned scr8(int unsigned x, int unsigned y);
      return 255 - (((255 - x) * (255 - y)) >> 8);
    endfunction

    function automatic void note_pair(pair_t it);
      int unsigned la, lb, p, q, r, f, g, h;
      bit          take_a;
      pix_t        e;
      la = luma(it.a);
      lb = luma(it.b);
      take_a = (mode == MODE_DARKEN) ? (la <= lb) : (la >= lb);
      for (int i = 0; i < 3; i++) begin
        case (mode)
          MODE_MUL:     p = mul8(it.a[i], it.b[i]);
          MODE_SCREEN:  p = scr8(it.a[i], it.b[i]);
          MODE_DARKEN, MODE_LIGHTEN: p = take_a ? it.a[i] : it.b[i];
          MODE_OVERLAY: p = (la < 128) ? mul8(it.a[i], it.b[i]) : scr8(it.a[i], it.b[i]);
          MODE_DODGE: begin
            if (it.b[i] == 255) p = 255;
            else begin
              q = (int'(it.a[i]) << 8) / (255 - it.b[i]);
              p = (q > 255) ? 255 : q;
            end
          end
          MODE_BURN: begin
            if (it.b[i] == 0) p = 0;
            else begin
              q = ((255 - int'(it.a[i])) << 8) / it.b[i];
              p = (q > 255) ? 0 : 255 - q;
            end
          end
          default: p = it.a[i];
        endcase
        if (amt < 128) begin
          f = (amt * 2) & 8'hff;
          r = (f * p + ((255 - f) & 8'hff) * it.a[i]) >> 8;
        end else begin
          g = (510 - amt * 2) & 8'hff;
          h = (amt * 2 - 256) & 8'hff;
          r = (g * p + h * it.b[i]) >> 8;
        end
        e.c[i] = r[7:0];
      end
      pending.push_back(e);
    endfunction

    function automatic void check_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      pix_t e;
      if (pending.size() == 0) begin
        $error("unexpected pixel %h %h %h", c0, c1, c2);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (c0 !== e.c[0]) begin
        $error("out_chan0 expected %h actual %h", e.c[0], c0); errors++;
      end
      if (c1 !== e.c[1]) begin
        $error("out_chan1 expected %h actual %h", e.c[1], c1); errors++;
      end
      if (c2 !== e.c[2]) begin
        $error("out_chan2 expected %h actual %h", e.c[2], c2); errors++;
      end
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i, in_ready_o;
  logic [7:0] a_chan0_i, a_chan1_i, a_chan2_i, b_chan0_i, b_chan1_i, b_chan2_i;
  logic       out_valid_o, out_ready_i;
  logic [7:0] out_chan0_o, out_chan1_o, out_chan2_o;

  blend_board board;
  bit         hold_long;
  bit         feeding_done;

  rgb_layer_blend_mixer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_MODE) board.mode = val[2:0];
    else board.amt = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pair(pair_t it, bit gaps);
    int unsigned w;
    w = gaps ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w != 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    a_chan0_i <= it.a[0]; a_chan1_i <= it.a[1]; a_chan2_i <= it.a[2];
    b_chan0_i <= it.b[0]; b_chan1_i <= it.b[1]; b_chan2_i <= it.b[2];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pair(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (NumStages + 4) @(negedge clk_i);
  endtask

  function automatic pair_t rand_pair();
    pair_t it;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0: it.a[i] = 8'h00;
        1: it.a[i] = 8'hff;
        default: it.a[i] = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0: it.b[i] = 8'h00;
        1: it.b[i] = 8'hff;
        default: it.b[i] = $urandom_range(0, 255);
      endcase
    end
    return it;
  endfunction

  function automatic pair_t flat_pair(logic [7:0] av, logic [7:0] bv);
    pair_t it;
    for (int i = 0; i < 3; i++) begin
      it.a[i] = av;
      it.b[i] = bv;
    end
    return it;
  endfunction

  // drain side
  initial begin
    int unsigned w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_long = 1'b0;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_pixel(out_chan0_o, out_chan1_o, out_chan2_o);
  end

  initial begin
    logic [7:0] amts [5];
    logic [7:0] edge_vals [6];
    board = new();
    hold_long = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    a_chan0_i = '0; a_chan1_i = '0; a_chan2_i = '0;
    b_chan0_i = '0; b_chan1_i = '0; b_chan2_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, then each mode at edge values
    edge_vals = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f};
    send_pair(flat_pair(8'hff, 8'h00), 1'b0);
    send_pair(flat_pair(8'h00, 8'hff), 1'b0);
    drain();
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_IDX_MODE, 8'(m));
      write_reg(CFG_IDX_AMOUNT, (m % 2) ? 8'd255 : 8'd0);
      for (int k = 0; k < 3; k++)
        send_pair(flat_pair(edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)]),
                  1'b0);
      drain();
    end

    // random phases over modes and amounts, extremes included
    amts = '{8'd0, 8'd127, 8'd128, 8'd255, 8'd64};
    for (int ph = 0; ph < 26; ph++) begin
      write_reg(CFG_IDX_MODE, 8'($urandom_range(0, 7)));
      write_reg(CFG_IDX_AMOUNT, (ph < 5) ? amts[ph] : 8'($urandom_range(0, 255)));
      if (ph == 3) hold_long = 1'b1;
      for (int n = 0; n < 50; n++)
        send_pair(rand_pair(), ((ph % 4) != 1) && (ph != 3));
      drain();
    end

    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
